[rtl/binary_to_decimal_ascii_line_top_macros.svh]
// Assertion macros used by the converter's top-level RTL file.
`ifndef BINARY_TO_DECIMAL_ASCII_LINE_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_LINE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/b2da_pkg.sv]
// Shared types, constants and helpers of the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned DIGITS      = 10;
  localparam int unsigned BCD_W       = 4 * DIGITS;
  localparam int unsigned DIG_IDX_W   = $clog2(DIGITS);
  localparam int unsigned STAGE_STEPS = 8;

  localparam logic [7:0] CHR_ZERO = 8'd48;
  localparam logic [7:0] CHR_CR   = 8'd13;
  localparam logic [7:0] CHR_LF   = 8'd10;

  // Payload carried through the shift-and-add-3 pipeline
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
  } dab_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIGIT,
    S_CR,
    S_LF
  } ser_state_t;

  // Index of the most significant non-zero digit; zero when all digits are zero
  function automatic logic [DIG_IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
    logic [DIG_IDX_W-1:0] r;
    r = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        r = DIG_IDX_W'(d);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/b2da_dabble.sv]
// One registered stage of the double-dabble binary to BCD pipeline.
`default_nettype none

module b2da_dabble #(
  parameter int unsigned STEPS = b2da_pkg::STAGE_STEPS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  b2da_pkg::dab_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output b2da_pkg::dab_t out_data
);
  import b2da_pkg::*;

  logic valid_r, valid_nxt;
  dab_t data_r, data_nxt;

  always_comb begin : dab_steps
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < STEPS; s++) begin
      // add 3 to every digit of five or more, then shift one binary bit in
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
    end
    data_nxt.bcd = bcd;
    data_nxt.bin = bin;
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/b2da_ser.sv]
// Serialiser: turns one BCD word into digit beats followed by CR and LF.
`default_nettype none

module b2da_ser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [b2da_pkg::BCD_W-1:0] in_bcd,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast
);
  import b2da_pkg::*;

  ser_state_t           state_r, state_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]           digit;
  logic                 take;

  assign take  = in_valid && in_ready;
  assign digit = bcd_r[{idx_r, 2'b00} +: 4];

  // next state
  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_tready) begin
          if (idx_r == '0) begin
            state_nxt = S_CR;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      S_CR: begin
        if (out_tready) begin
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        if (out_tready) begin
          state_nxt = in_valid ? S_DIGIT : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (take) begin
      bcd_nxt = in_bcd;
      idx_nxt = top_digit(in_bcd);
    end
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    out_tvalid = 1'b0;
    out_tdata  = CHR_LF;
    out_tlast  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DIGIT: begin
        out_tvalid = 1'b1;
        out_tdata  = CHR_ZERO + {4'b0000, digit};
      end
      S_CR: begin
        out_tvalid = 1'b1;
        out_tdata  = CHR_CR;
      end
      S_LF: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
        in_ready   = out_tready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    idx_r <= idx_nxt;
  end

endmodule

`default_nettype wire

[rtl/binary_to_decimal_ascii_line_top.sv]
// Binary to decimal ASCII line converter. Each input beat carries an unsigned
// 32-bit number; the block answers with its decimal digits as ASCII, most
// significant first and without leading zeros, then CR and LF, tlast on the LF.
// Zero prints as "0". Conversion runs in a double-dabble pipeline of
// 32 / STAGE_STEPS register stages (four by default), which takes a new number
// every cycle while the serialiser is free. The serialiser sends one byte per
// cycle while out_tready is high, the digits and then CR and LF; it sets the
// sustained rate, and the pipeline buffers further numbers meanwhile.
`default_nettype none
`include "binary_to_decimal_ascii_line_top_macros.svh"

module binary_to_decimal_ascii_line_top #(
  parameter int unsigned STAGE_STEPS = b2da_pkg::STAGE_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] ascii_byte
  output logic        out_tlast
);
  import b2da_pkg::*;

  localparam int unsigned N_ST = NUM_W / STAGE_STEPS;

  logic st_valid [0:N_ST];
  logic st_ready [0:N_ST];
  dab_t st_data  [0:N_ST];

  assign st_valid[0] = in_tvalid;
  assign st_data[0]  = '{bcd: '0, bin: in_tdata[NUM_W-1:0]};
  assign in_tready   = st_ready[0];

  for (genvar g = 0; g < N_ST; g++) begin : g_stage
    b2da_dabble #(
      .STEPS(STAGE_STEPS)
    ) u_dabble (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (st_valid[g]),
      .in_ready (st_ready[g]),
      .in_data  (st_data[g]),
      .out_valid(st_valid[g+1]),
      .out_ready(st_ready[g+1]),
      .out_data (st_data[g+1])
    );
  end

  b2da_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[N_ST]),
    .in_ready  (st_ready[N_ST]),
    .in_bcd    (st_data[N_ST].bcd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  `B2DA_ASSERT_NOW(a_last_is_lf, out_tvalid && out_tlast, out_tdata == CHR_LF, "tlast on a byte other than LF")
  `B2DA_ASSERT_NEXT(a_cr_then_lf, out_tvalid && out_tready && out_tdata == CHR_CR, out_tvalid && out_tlast, "CR beat not followed by LF")
  `B2DA_ASSERT_NOW(a_digit_no_last, out_tvalid && out_tdata >= CHR_ZERO, !out_tlast, "tlast on a digit beat")

endmodule

`default_nettype wire
